/* hw/rtl/matrix_inverse_3x3_assert.svh */
// Assertion macros for the 3x3 matrix inverse.
`ifndef MATRIX_INVERSE_3X3_ASSERT_SVH
`define MATRIX_INVERSE_3X3_ASSERT_SVH
`ifndef SYNTHESIS
`define MI3_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("mi3 assertion failed");
`define MI3_HOLD(lbl, cond, sig) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> $stable(sig)) \
        else $error("mi3 hold check failed");
`else
`define MI3_ASSERT(lbl, prop)
`define MI3_HOLD(lbl, cond, sig)
`endif
`endif

/* hw/rtl/mi3_pkg.sv */
package mi3_pkg;

    localparam int MAT_DIM = 3;
    localparam int N_ELEM  = MAT_DIM * MAT_DIM;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGULAR = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Cofactor k is a[P]*a[Q] - a[R]*a[S], elements in row-major order.
    localparam logic [3:0] COF_P [N_ELEM] = '{4'd4, 4'd2, 4'd1, 4'd5, 4'd0, 4'd2, 4'd3, 4'd1, 4'd0};
    localparam logic [3:0] COF_Q [N_ELEM] = '{4'd8, 4'd7, 4'd5, 4'd6, 4'd8, 4'd3, 4'd7, 4'd6, 4'd4};
    localparam logic [3:0] COF_R [N_ELEM] = '{4'd5, 4'd1, 4'd2, 4'd3, 4'd2, 4'd0, 4'd4, 4'd0, 4'd1};
    localparam logic [3:0] COF_S [N_ELEM] = '{4'd7, 4'd8, 4'd4, 4'd8, 4'd6, 4'd5, 4'd6, 4'd7, 4'd3};

endpackage

/* hw/rtl/matrix_inverse_3x3.sv */
// Channel   Direction  Handshake              Payload
// input     in         i_valid / o_stall      i_a00 .. i_a22
// output    out        o_valid / i_stall      o_inv00 .. o_inv22, o_status
//
// One item enters per cycle unless o_stall is high. Each item passes through five
// stages of products, cofactors, determinant and magnitude preparation, then
// through the one-quotient-bit-per-stage divider lanes.
// Synchronous active-low reset clears only the stage valid bits.
// While the last stage holds an item and i_stall is high, every stage holds.
`include "matrix_inverse_3x3_assert.svh"
module matrix_inverse_3x3 import mi3_pkg::*; #(
    parameter int DATA_WIDTH = 32,
    parameter int FRAC_BITS  = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [DATA_WIDTH-1:0] i_a00,
    input  logic signed [DATA_WIDTH-1:0] i_a01,
    input  logic signed [DATA_WIDTH-1:0] i_a02,
    input  logic signed [DATA_WIDTH-1:0] i_a10,
    input  logic signed [DATA_WIDTH-1:0] i_a11,
    input  logic signed [DATA_WIDTH-1:0] i_a12,
    input  logic signed [DATA_WIDTH-1:0] i_a20,
    input  logic signed [DATA_WIDTH-1:0] i_a21,
    input  logic signed [DATA_WIDTH-1:0] i_a22,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [DATA_WIDTH-1:0] o_inv00,
    output logic signed [DATA_WIDTH-1:0] o_inv01,
    output logic signed [DATA_WIDTH-1:0] o_inv02,
    output logic signed [DATA_WIDTH-1:0] o_inv10,
    output logic signed [DATA_WIDTH-1:0] o_inv11,
    output logic signed [DATA_WIDTH-1:0] o_inv12,
    output logic signed [DATA_WIDTH-1:0] o_inv20,
    output logic signed [DATA_WIDTH-1:0] o_inv21,
    output logic signed [DATA_WIDTH-1:0] o_inv22,
    output logic [1:0]                   o_status
);
    localparam int W  = DATA_WIDTH;
    localparam int F  = FRAC_BITS;
    localparam int CW = 2 * W + 1;
    localparam int DW = 3 * W + 3;
    localparam int NW = 2 * W + 2 * F + 1;
    localparam int L  = W + 7;

    logic          w_en;
    logic [L-1:0]  r_vld;

    logic signed [W-1:0]  w_a    [N_ELEM];
    logic signed [CW-1:0] w_c    [N_ELEM];
    logic signed [W-1:0]  w_row0 [MAT_DIM];
    logic signed [CW-1:0] w_c0   [MAT_DIM];
    logic signed [DW-1:0] w_det;

    logic signed [CW-1:0] r_c3 [N_ELEM];
    logic signed [CW-1:0] r_c4 [N_ELEM];
    logic [NW-1:0]        r_num [N_ELEM];
    logic                 r_neg [N_ELEM];
    logic [DW-1:0]        r_dmag;
    logic                 r_zero;

    logic signed [W-1:0]  w_inv  [N_ELEM];
    logic                 w_sat  [N_ELEM];
    logic                 w_zero [N_ELEM];
    logic                 w_any_sat;
    logic                 w_diag_zero;

    assign o_stall = r_vld[L-1] && i_stall;
    assign w_en    = !o_stall;
    assign o_valid = r_vld[L-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[L-2:0], i_valid};
        end
    end

    assign w_a[0] = i_a00;
    assign w_a[1] = i_a01;
    assign w_a[2] = i_a02;
    assign w_a[3] = i_a10;
    assign w_a[4] = i_a11;
    assign w_a[5] = i_a12;
    assign w_a[6] = i_a20;
    assign w_a[7] = i_a21;
    assign w_a[8] = i_a22;

    mi3_cof #(.W(W)) u_cof (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_a    (w_a),
        .o_c    (w_c),
        .o_row0 (w_row0)
    );

    assign w_c0[0] = w_c[0];
    assign w_c0[1] = w_c[3];
    assign w_c0[2] = w_c[6];

    mi3_det #(.W(W)) u_det (
        .i_clk (i_clk),
        .i_en  (w_en),
        .i_a   (w_row0),
        .i_c   (w_c0),
        .o_det (w_det)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_c3[k]  <= w_c[k];
                r_c4[k]  <= r_c3[k];
                r_num[k] <= {(r_c4[k][CW-1] ? CW'(-r_c4[k]) : CW'(r_c4[k])),
                             {(2*F){1'b0}}};
                r_neg[k] <= r_c4[k][CW-1] ^ w_det[DW-1];
            end
            r_dmag <= w_det[DW-1] ? DW'(-w_det) : DW'(w_det);
            r_zero <= w_det == '0;
        end
    end

    for (genvar k = 0; k < N_ELEM; k++) begin : g_lane
        mi3_div #(.W(W), .F(F)) u_div (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_num  (r_num[k]),
            .i_dmag (r_dmag),
            .i_neg  (r_neg[k]),
            .i_zero (r_zero),
            .o_inv  (w_inv[k]),
            .o_sat  (w_sat[k]),
            .o_zero (w_zero[k])
        );
    end

    always_comb begin
        w_any_sat = 1'b0;
        for (int k = 0; k < N_ELEM; k++) begin
            w_any_sat = w_any_sat | w_sat[k];
        end
    end

    assign o_status = w_zero[0] ? ST_SINGULAR : (w_any_sat ? ST_OVERFLOW : ST_OK);

    assign o_inv00 = w_inv[0];
    assign o_inv01 = w_inv[1];
    assign o_inv02 = w_inv[2];
    assign o_inv10 = w_inv[3];
    assign o_inv11 = w_inv[4];
    assign o_inv12 = w_inv[5];
    assign o_inv20 = w_inv[6];
    assign o_inv21 = w_inv[7];
    assign o_inv22 = w_inv[8];

    assign w_diag_zero = (o_inv00 == '0) && (o_inv11 == '0) && (o_inv22 == '0);

    `MI3_HOLD(a_frozen_pipe, o_valid && i_stall, r_vld)
    `MI3_ASSERT(a_accept_enters, (i_valid && !o_stall) |=> r_vld[0])
    `MI3_ASSERT(a_singular_zero, (o_valid && o_status == ST_SINGULAR) |-> w_diag_zero)
endmodule

/* hw/rtl/mi3_cof.sv */
module mi3_cof import mi3_pkg::*; #(
    parameter int W = 32
) (
    input  logic                 i_clk,
    input  logic                 i_en,
    input  logic signed [W-1:0]  i_a    [N_ELEM],
    output logic signed [2*W:0]  o_c    [N_ELEM],
    output logic signed [W-1:0]  o_row0 [MAT_DIM]
);
    localparam int PW = 2 * W;
    localparam int CW = 2 * W + 1;

    logic signed [PW-1:0] r_pq   [N_ELEM];
    logic signed [PW-1:0] r_rs   [N_ELEM];
    logic signed [CW-1:0] r_c    [N_ELEM];
    logic signed [W-1:0]  r_row1 [MAT_DIM];
    logic signed [W-1:0]  r_row2 [MAT_DIM];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < N_ELEM; k++) begin
                r_pq[k] <= PW'(i_a[COF_P[k]] * i_a[COF_Q[k]]);
                r_rs[k] <= PW'(i_a[COF_R[k]] * i_a[COF_S[k]]);
                r_c[k]  <= CW'(r_pq[k]) - CW'(r_rs[k]);
            end
            for (int j = 0; j < MAT_DIM; j++) begin
                r_row1[j] <= i_a[j];
                r_row2[j] <= r_row1[j];
            end
        end
    end

    assign o_c    = r_c;
    assign o_row0 = r_row2;
endmodule

/* hw/rtl/mi3_det.sv */
module mi3_det import mi3_pkg::*; #(
    parameter int W = 32
) (
    input  logic                   i_clk,
    input  logic                   i_en,
    input  logic signed [W-1:0]    i_a [MAT_DIM],
    input  logic signed [2*W:0]    i_c [MAT_DIM],
    output logic signed [3*W+2:0]  o_det
);
    localparam int CW  = 2 * W + 1;
    localparam int PPW = 2 * W + 1;
    localparam int DW  = 3 * W + 3;

    logic signed [PPW-1:0] r_lo [MAT_DIM];
    logic signed [PPW-1:0] r_hi [MAT_DIM];
    logic signed [DW-1:0]  r_det;
    logic signed [DW-1:0]  n_det;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < MAT_DIM; k++) begin
                r_lo[k] <= PPW'(i_a[k] * $signed({1'b0, i_c[k][W-1:0]}));
                r_hi[k] <= PPW'(i_a[k] * $signed(i_c[k][CW-1:W]));
            end
            r_det <= n_det;
        end
    end

    always_comb begin
        n_det = '0;
        for (int k = 0; k < MAT_DIM; k++) begin
            n_det = n_det + (DW'(r_hi[k]) <<< W) + DW'(r_lo[k]);
        end
    end

    assign o_det = r_det;
endmodule

/* hw/rtl/mi3_div.sv */
module mi3_div import mi3_pkg::*; #(
    parameter int W = 32,
    parameter int F = 16
) (
    input  logic                      i_clk,
    input  logic                      i_en,
    input  logic [2*W+2*F:0]          i_num,
    input  logic [3*W+2:0]            i_dmag,
    input  logic                      i_neg,
    input  logic                      i_zero,
    output logic signed [W-1:0]       o_inv,
    output logic                      o_sat,
    output logic                      o_zero
);
    localparam int NW = 2 * W + 2 * F + 1;
    localparam int DW = 3 * W + 3;
    localparam int RW = DW + 1;
    localparam int XW = (NW > DW + W) ? NW : DW + W;

    logic [DW-1:0] r_rem [W+1];
    logic [DW-1:0] r_d   [W+1];
    logic [W-1:0]  r_nl  [W+1];
    logic [W-1:0]  r_q   [W+1];
    logic          r_ng  [W+1];
    logic          r_zr  [W+1];
    logic          r_ov  [W+1];

    logic signed [W-1:0] r_inv;
    logic                r_sat;
    logic                r_zero;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0] <= DW'(i_num >> W);
            r_d[0]   <= i_dmag;
            r_nl[0]  <= i_num[W-1:0];
            r_q[0]   <= '0;
            r_ng[0]  <= i_neg;
            r_zr[0]  <= i_zero;
            r_ov[0]  <= XW'(i_num) >= XW'({i_dmag, {W{1'b0}}});
        end
    end

    for (genvar s = 0; s < W; s++) begin : g_step
        logic [RW-1:0] w_sh;
        logic [RW-1:0] w_diff;
        logic          w_ge;

        assign w_sh   = {r_rem[s], r_nl[s][W-1-s]};
        assign w_ge   = w_sh >= RW'(r_d[s]);
        assign w_diff = w_sh - RW'(r_d[s]);

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[s+1] <= w_ge ? w_diff[DW-1:0] : w_sh[DW-1:0];
                r_q[s+1]   <= {r_q[s][W-2:0], w_ge};
                r_d[s+1]   <= r_d[s];
                r_nl[s+1]  <= r_nl[s];
                r_ng[s+1]  <= r_ng[s];
                r_zr[s+1]  <= r_zr[s];
                r_ov[s+1]  <= r_ov[s];
            end
        end
    end

    logic [W-1:0] w_lim;
    logic         w_sat;
    logic [W-1:0] w_mag;

    assign w_lim = r_ng[W] ? {1'b1, {(W-1){1'b0}}} : {1'b0, {(W-1){1'b1}}};
    assign w_sat = r_ov[W] || (r_q[W] > w_lim);
    assign w_mag = w_sat ? w_lim : r_q[W];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_inv  <= r_zr[W] ? '0 : (r_ng[W] ? $signed(-w_mag) : $signed(w_mag));
            r_sat  <= !r_zr[W] && w_sat;
            r_zero <= r_zr[W];
        end
    end

    assign o_inv  = r_inv;
    assign o_sat  = r_sat;
    assign o_zero = r_zero;
endmodule
